@@ src/ml1ks_pkg.sv @@
// ----------------------------------------------------------------------------
// ml1ks_pkg: shared types and helpers for the exact-k max L1 subset sum
// Payload structs, cell control, sum types and the sign-pattern offset.
// ----------------------------------------------------------------------------
package ml1ks_pkg;

  localparam int unsigned MAX_ITEMS_DEF = 1024;
  localparam int unsigned NUM_PAT       = 8;
  localparam int unsigned PAT_W         = 3;
  localparam int unsigned COMP_W        = 24;
  localparam int unsigned OFS_W         = 26;
  localparam int unsigned SUM_W         = 36;
  localparam int unsigned SCORE_W       = 35;
  localparam int unsigned PICK_W        = 11;

  typedef logic signed [OFS_W-1:0] ofs_t;
  typedef logic signed [SUM_W-1:0] sum_t;
  typedef sum_t [NUM_PAT-1:0]      ring_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] comp_x;
    logic signed [COMP_W-1:0] comp_y;
    logic signed [COMP_W-1:0] comp_z;
    logic                     is_last;
  } in_t;

  typedef struct packed {
    logic [SCORE_W-1:0] best_score;
    logic               too_few;
  } out_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_UPDATE,
    OP_ROTATE,
    OP_SHIFT
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    ofs_t     c;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SHIFT,
    ST_MAX
  } state_e;

  // Signed offset of one vector under a sign pattern: bit j set negates component j.
  function automatic ofs_t pat_offset(in_t item, logic [PAT_W-1:0] p);
    ofs_t x;
    ofs_t y;
    ofs_t z;
    x = OFS_W'(item.comp_x);
    y = OFS_W'(item.comp_y);
    z = OFS_W'(item.comp_z);
    return (p[0] ? -x : x) + (p[1] ? -y : y) + (p[2] ? -z : z);
  endfunction

endpackage

@@ src/ml1ks_cell.sv @@
// ----------------------------------------------------------------------------
// ml1ks_cell: one chosen-count slot of the best-sum chain
// Holds the best sums of all sign patterns for one count in a rotating ring.
// ----------------------------------------------------------------------------
module ml1ks_cell #(
  parameter int unsigned MAX_ITEMS = ml1ks_pkg::MAX_ITEMS_DEF,
  parameter int unsigned IDX       = 0
) (
  input  logic                               clk_i,
  input  ml1ks_pkg::cell_ctrl_t              ctrl_i,
  input  logic [$clog2(MAX_ITEMS+1)-1:0]     seen_i,
  input  ml1ks_pkg::sum_t                    prev_head_i,
  input  ml1ks_pkg::ring_t                   upper_ring_i,
  output ml1ks_pkg::sum_t                    head_o,
  output ml1ks_pkg::ring_t                   ring_o
);
  import ml1ks_pkg::*;

  localparam int unsigned SEEN_W = $clog2(MAX_ITEMS + 1);

  ring_t ring_q;
  ring_t ring_d;
  sum_t  head;
  sum_t  cand;
  sum_t  upd;
  logic  active;
  logic  forced;

  always_comb begin
    head   = ring_q[0];
    cand   = prev_head_i + {{(SUM_W - OFS_W){ctrl_i.c[OFS_W-1]}}, ctrl_i.c};
    active = (SEEN_W'(IDX) <= seen_i);
    forced = (SEEN_W'(IDX) == seen_i);
    upd    = head;
    if (active && (forced || ($signed(cand) > $signed(head)))) begin
      upd = cand;
    end

    ring_d = ring_q;
    unique case (ctrl_i.op)
      OP_HOLD: begin
        ring_d = ring_q;
      end
      OP_UPDATE: begin
        for (int i = 0; i < NUM_PAT - 1; i++) begin
          ring_d[i] = ring_q[i+1];
        end
        ring_d[NUM_PAT-1] = upd;
      end
      OP_ROTATE: begin
        for (int i = 0; i < NUM_PAT - 1; i++) begin
          ring_d[i] = ring_q[i+1];
        end
        ring_d[NUM_PAT-1] = head;
      end
      OP_SHIFT: begin
        ring_d = upper_ring_i;
      end
      default: begin
        ring_d = ring_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    ring_q <= ring_d;
  end

  assign head_o = ring_q[0];
  assign ring_o = ring_q;

endmodule

@@ src/ml1ks_ctrl.sv @@
// ----------------------------------------------------------------------------
// ml1ks_ctrl: sequencer of the best-sum chain
// Steps sign patterns, counts items, shifts out the chosen row, forms result.
// ----------------------------------------------------------------------------
module ml1ks_ctrl #(
  parameter int unsigned MAX_ITEMS = ml1ks_pkg::MAX_ITEMS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  ml1ks_pkg::in_t                     in_i,
  output logic                               done_o,
  output ml1ks_pkg::out_t                    out_o,
  input  logic                               cfg_we_i,
  input  logic [ml1ks_pkg::PICK_W-1:0]       cfg_wdata_i,
  input  ml1ks_pkg::sum_t                    head0_i,
  output ml1ks_pkg::cell_ctrl_t              ctrl_o,
  output logic [$clog2(MAX_ITEMS+1)-1:0]     seen_o
);
  import ml1ks_pkg::*;

  localparam int unsigned SEEN_W = $clog2(MAX_ITEMS + 1);
  localparam int unsigned CMP_W  = (SEEN_W > PICK_W) ? SEEN_W : PICK_W;
  localparam logic [PAT_W-1:0] PAT_LAST = PAT_W'(NUM_PAT - 1);

  state_e              state_q, state_d;
  logic [PAT_W-1:0]    pat_q, pat_d;
  logic [SEEN_W-1:0]   seen_q, seen_d;
  logic [SEEN_W-1:0]   seen_next;
  logic [PICK_W-1:0]   pick_q, pick_d;
  logic [PICK_W-1:0]   cnt_q, cnt_d;
  in_t                 item_q, item_d;
  ofs_t                c_q, c_d;
  sum_t                max_q, max_d;
  logic                done_q, done_d;
  out_t                res_q, res_d;

  always_comb begin
    state_d   = state_q;
    pat_d     = pat_q;
    seen_d    = seen_q;
    pick_d    = cfg_we_i ? cfg_wdata_i : pick_q;
    cnt_d     = cnt_q;
    item_d    = item_q;
    c_d       = c_q;
    max_d     = max_q;
    done_d    = 1'b0;
    res_d     = res_q;
    ctrl_o.op = OP_HOLD;
    ctrl_o.c  = c_q;
    seen_next = (seen_q == SEEN_W'(MAX_ITEMS)) ? seen_q : seen_q + 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          item_d  = in_i;
          c_d     = pat_offset(in_i, '0);
          pat_d   = '0;
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        ctrl_o.op = OP_UPDATE;
        pat_d     = pat_q + 1'b1;
        c_d       = pat_offset(item_q, pat_q + 1'b1);
        if (pat_q == PAT_LAST) begin
          if (!item_q.is_last) begin
            seen_d  = seen_next;
            state_d = ST_IDLE;
          end else begin
            seen_d = '0;
            priority if (pick_q == '0) begin
              res_d   = '{best_score: '0, too_few: 1'b0};
              done_d  = 1'b1;
              state_d = ST_IDLE;
            end else if (CMP_W'(pick_q) > CMP_W'(seen_next)) begin
              res_d   = '{best_score: '0, too_few: 1'b1};
              done_d  = 1'b1;
              state_d = ST_IDLE;
            end else if (pick_q == PICK_W'(1)) begin
              max_d   = '0;
              pat_d   = '0;
              state_d = ST_MAX;
            end else begin
              cnt_d   = pick_q - 1'b1;
              state_d = ST_SHIFT;
            end
          end
        end
      end
      ST_SHIFT: begin
        // advance every ring one cell toward the chain head
        ctrl_o.op = OP_SHIFT;
        cnt_d     = cnt_q - 1'b1;
        if (cnt_q == PICK_W'(1)) begin
          max_d   = '0;
          pat_d   = '0;
          state_d = ST_MAX;
        end
      end
      ST_MAX: begin
        ctrl_o.op = OP_ROTATE;
        pat_d     = pat_q + 1'b1;
        if ($signed(head0_i) > $signed(max_q)) begin
          max_d = head0_i;
        end
        if (pat_q == PAT_LAST) begin
          res_d   = '{best_score: max_d[SCORE_W-1:0], too_few: 1'b0};
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pat_q   <= '0;
      seen_q  <= '0;
      pick_q  <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pat_q   <= pat_d;
      seen_q  <= seen_d;
      pick_q  <= pick_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    c_q    <= c_d;
    max_q  <= max_d;
    res_q  <= res_d;
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign out_o  = res_q;
  assign seen_o = seen_q;

endmodule

@@ src/max_l1_norm_k_subset_sum.sv @@
// ----------------------------------------------------------------------------
// max_l1_norm_k_subset_sum: exact-k maximum L1-norm subset sum
// Vectors of three signed 24-bit components arrive one per transfer (start
// high while busy is low); the last vector of a set is marked by is_last.
// The block picks exactly pick_count vectors so that |sum x|+|sum y|+|sum z| is
// largest and reports it once per set on out_o, marked by a one-cycle done_o
// strobe that cannot be held off, so the receiver must take it when it comes.
// Each vector holds busy high through one update step per sign pattern, as
// the chain of MAX_ITEMS cells updates all counts of one pattern per cycle;
// start is sampled in the idle cycle that follows, so a new vector is taken
// only once the last is through. On the last vector of a set, readout shifts
// the chosen count's row down the chain to cell 0, then searches the maximum
// over the patterns; a zero count or a set shorter than pick_count reports
// right after the update steps. done_o can rise in the cycle busy drops, so
// the next set may start immediately. pick_count (cfg_we_i/cfg_wdata_i) is to
// be written only while idle, by the user; the block does not enforce it.
// ----------------------------------------------------------------------------
module max_l1_norm_k_subset_sum #(
  parameter int unsigned MAX_ITEMS = ml1ks_pkg::MAX_ITEMS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  ml1ks_pkg::in_t                in_i,
  output logic                          done_o,
  output ml1ks_pkg::out_t               out_o,
  input  logic                          cfg_we_i,
  input  logic [ml1ks_pkg::PICK_W-1:0]  cfg_wdata_i
);
  import ml1ks_pkg::*;

  localparam int unsigned SEEN_W = $clog2(MAX_ITEMS + 1);

  cell_ctrl_t          cell_ctrl;
  logic [SEEN_W-1:0]   seen;
  sum_t                head_w [MAX_ITEMS];
  ring_t               ring_w [MAX_ITEMS];

  // Sequencer: pattern stepping, item count, readout and result register.
  ml1ks_ctrl #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .in_i        (in_i),
    .done_o      (done_o),
    .out_o       (out_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .head0_i     (head_w[0]),
    .ctrl_o      (cell_ctrl),
    .seen_o      (seen)
  );

  // Chain of cells: cell k keeps the best sums for k+1 chosen vectors.
  // Each cell reads the old head of the cell below (one fewer chosen) to
  // build its candidate, so all counts of a pattern update in the same cycle
  // with the same effect as a top-down sweep. During readout the rings
  // move down one cell per cycle toward cell 0.
  for (genvar k = 0; k < MAX_ITEMS; k++) begin : g_cell
    sum_t  prev_head;
    ring_t upper_ring;

    if (k == 0) begin : g_first
      assign prev_head = '0;
    end else begin : g_mid
      assign prev_head = head_w[k-1];
    end

    if (k == MAX_ITEMS - 1) begin : g_last
      assign upper_ring = '0;
    end else begin : g_below
      assign upper_ring = ring_w[k+1];
    end

    ml1ks_cell #(
      .MAX_ITEMS (MAX_ITEMS),
      .IDX       (k)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (cell_ctrl),
      .seen_i       (seen),
      .prev_head_i  (prev_head),
      .upper_ring_i (upper_ring),
      .head_o       (head_w[k]),
      .ring_o       (ring_w[k])
    );
  end

endmodule
